/* design/assert_macros.svh */
// Assertion macros used by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold in every clock cycle outside reset
`define SVNA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define SVNA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

/* design/svna_pkg.sv */
// Types, codes and constants of the smooth vertex normal accumulator
package svna_pkg;

  // Operation codes of an input word
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_TRI   = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  // Source of the vector fed to the normalisation unit
  typedef enum logic [1:0] {
    NSEL_A   = 2'd0,
    NSEL_B   = 2'd1,
    NSEL_SUM = 2'd2
  } norm_sel_e;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_CLR,
    ST_IDLE,
    ST_DECODE,
    ST_LOAD,
    ST_TRI_CHK,
    ST_TRI_RD,
    ST_TRI_CAP,
    ST_NA_GO,
    ST_NA_WAIT,
    ST_NB_GO,
    ST_NB_WAIT,
    ST_CROSS,
    ST_ACC_RD,
    ST_ACC_WR,
    ST_RD_RD,
    ST_RD_CHK,
    ST_RD_WAIT,
    ST_RES
  } ctrl_state_e;

  // Normalisation unit states
  typedef enum logic [2:0] {
    NS_IDLE,
    NS_SHIFT,
    NS_SQ,
    NS_SQRT,
    NS_DINIT,
    NS_DIV,
    NS_DONE
  } norm_state_e;

  typedef logic signed [34:0] vec_t;
  typedef logic signed [31:0] unit_t;

  localparam logic [1:0]  CORNER0     = 2'd0;
  localparam logic [1:0]  LAST_CORNER = 2'd2;
  localparam logic [2:0]  CROSS_LAST  = 3'd6;
  localparam logic [15:0] COUNT_MAX   = 16'hFFFF;
  localparam logic        REG_VERTEX_COUNT = 1'b0;

  // Controller to datapath
  typedef struct packed {
    logic      accept;
    logic      pos_wr;
    logic      pos_rd;
    logic      pos_cap;
    logic [1:0] corner;
    logic      norm_start;
    norm_sel_e norm_sel;
    logic      a_cap;
    logic      b_cap;
    logic      cross_en;
    logic [2:0] step;
    logic      acc_rd;
    logic      acc_wr;
    logic      acc_clr;
    logic      out_load;
    logic      out_use_norm;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_e  op;
    logic in_range0;
    logic in_range_all;
    logic rd_used;
    logic norm_done;
    logic norm_ok;
    logic clr_last;
    logic out_busy;
  } sts_t;

endpackage

/* design/smooth_vertex_normal_accumulator_unit.sv */
// Top level: smooth vertex normal accumulator with APB configuration
//
// Input words (opcode, indices, position) arrive on a valid/ready channel;
// a read of a normal returns one word on a valid/ready output channel.
// vertex_count sits at APB byte address 0; pready is always high.
// One word is worked on at a time:
//   load writes its position; clear sweeps one accumulator entry a cycle;
//   triangle makes two passes through the shared
//   normaliser (bit-serial square root, 32 steps, then three 31-step
//   divisions) plus seven multiplier steps and three read-modify-writes;
//   a zero edge skips most of its pass;
//   read makes one normaliser pass with 15-step divisions, none with no normal.
// Dropped triangles end after the range check; out of range loads write nothing.
// After reset the accumulator store is swept to zero with in_ready_o low;
// APB writes are taken throughout.
// A result waits in an output register; a stalled receiver holds only the
// next read at its final step, other words keep going.
module smooth_vertex_normal_accumulator_unit import svna_pkg::*; #(
  parameter int unsigned MAX_VERTICES = 2048
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         opcode_i,
  input  logic [10:0]        vertex_index_i,
  input  logic [10:0]        second_index_i,
  input  logic [10:0]        third_index_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [10:0]        out_vertex_o,
  output logic signed [15:0] normal_x_o,
  output logic signed [15:0] normal_y_o,
  output logic signed [15:0] normal_z_o,
  output logic               no_normal_o
);

  `include "assert_macros.svh"

  logic [11:0] vertex_count_q;
  cmd_t        cmd;
  sts_t        sts;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_VERTEX_COUNT) ? {20'd0, vertex_count_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_count_q <= '0;
    end else if (psel && penable && pwrite && paddr[2] == REG_VERTEX_COUNT) begin
      vertex_count_q <= pwdata[11:0];
    end
  end

  svna_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  svna_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .vertex_count_i (vertex_count_q),
    .opcode_i       (opcode_i),
    .vertex_index_i (vertex_index_i),
    .second_index_i (second_index_i),
    .third_index_i  (third_index_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .pos_z_i        (pos_z_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_vertex_o   (out_vertex_o),
    .normal_x_o     (normal_x_o),
    .normal_y_o     (normal_y_o),
    .normal_z_o     (normal_z_o),
    .no_normal_o    (no_normal_o)
  );

  // A result word is never loaded over one still waiting
  `SVNA_ASSERT(a_no_overwrite, !cmd.out_load || !(out_valid_o && !out_ready_i), "result overwritten")
  // No word is taken while the accumulator store is being swept
  `SVNA_ASSERT(a_clr_not_ready, !cmd.acc_clr || !in_ready_o, "word accepted during clear sweep")
  // Only one word is taken at a time
  `SVNA_ASSERT_NEXT(a_one_word, in_valid_i && in_ready_o, !in_ready_o, "second word taken early")

endmodule

/* design/svna_norm.sv */
// Iterative vector normalisation unit: shift, squares, square root, division
module svna_norm import svna_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  logic  frac14_i,
  input  vec_t  vec_i [3],
  output logic  done_o,
  output logic  ok_o,
  output unit_t unit_o [3]
);

  norm_state_e state_q, state_d;
  logic [34:0] m_q [3];
  logic [2:0]  neg_q;
  logic        frac14_q, ok_q;
  logic [4:0]  cnt_q;
  logic [1:0]  comp_q;
  logic [61:0] sq_q;
  logic [62:0] res_q;
  logic [31:0] r_q;
  logic [30:0] q_q [3];

  logic [34:0] abs_in [3];
  logic        in_zero, too_big, too_small;
  logic [1:0]  msel;
  logic [29:0] m30;
  logic [59:0] prod;
  logic [62:0] bit_w;
  logic [63:0] trial;
  logic        take;
  logic [30:0] len;
  logic [31:0] den;
  logic [61:0] nn;
  logic [31:0] r_init;
  logic [32:0] r_shift;
  logic        fits;

  // Magnitudes of the incoming vector
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      abs_in[i] = vec_i[i][34] ? 35'(-vec_i[i]) : 35'(vec_i[i]);
    end
    in_zero = (vec_i[0] == '0) && (vec_i[1] == '0) && (vec_i[2] == '0);
  end

  // Range of the largest magnitude
  assign too_big   = |{m_q[0][34:30], m_q[1][34:30], m_q[2][34:30]};
  assign too_small = ~|{m_q[0][34:29], m_q[1][34:29], m_q[2][34:29]};

  // Component select, shared by squares and division
  assign msel = (state_q == NS_SQ) ? cnt_q[1:0] : comp_q;
  always_comb begin
    case (msel)
      2'd0:    m30 = m_q[0][29:0];
      2'd1:    m30 = m_q[1][29:0];
      default: m30 = m_q[2][29:0];
    endcase
  end
  assign prod = m30 * m30;

  // Square root step, one result bit per cycle
  assign bit_w = 63'(1) << {cnt_q, 1'b0};
  assign trial = {1'b0, res_q} + {1'b0, bit_w};
  assign take  = {2'b00, sq_q} >= trial;

  // Division step: numerator m*2^(f+1)+len, divisor 2*len
  assign len     = res_q[30:0];
  assign den     = {len, 1'b0};
  assign nn      = (frac14_q ? {17'd0, m30, 15'd0} : {1'b0, m30, 31'd0}) + 62'(len);
  assign r_init  = frac14_q ? nn[46:15] : {1'b0, nn[61:31]};
  assign r_shift = {r_q, nn[cnt_q]};
  assign fits    = r_shift >= {1'b0, den};

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      NS_IDLE:  if (start_i) state_d = in_zero ? NS_DONE : NS_SHIFT;
      NS_SHIFT: if (!too_big && !too_small) state_d = NS_SQ;
      NS_SQ:    if (cnt_q == 5'd2) state_d = NS_SQRT;
      NS_SQRT:  if (cnt_q == 5'd0) state_d = NS_DINIT;
      NS_DINIT: state_d = NS_DIV;
      NS_DIV: begin
        if (cnt_q == 5'd0) state_d = (comp_q == LAST_CORNER) ? NS_DONE : NS_DINIT;
      end
      NS_DONE:  state_d = NS_IDLE;
      default:  state_d = NS_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    done_o = (state_q == NS_DONE);
    ok_o   = ok_q;
    for (int i = 0; i < 3; i++) begin
      unit_o[i] = neg_q[i] ? -$signed({1'b0, q_q[i]}) : $signed({1'b0, q_q[i]});
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= NS_IDLE;
      cnt_q   <= '0;
      comp_q  <= '0;
      ok_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        NS_IDLE: begin
          if (start_i) begin
            cnt_q  <= '0;
            comp_q <= '0;
            ok_q   <= !in_zero;
          end
        end
        NS_SQ:    cnt_q <= (cnt_q == 5'd2) ? 5'd31 : cnt_q + 5'd1;
        NS_SQRT:  cnt_q <= cnt_q - 5'd1;
        NS_DINIT: cnt_q <= frac14_q ? 5'd14 : 5'd30;
        NS_DIV: begin
          cnt_q <= cnt_q - 5'd1;
          if (cnt_q == 5'd0) comp_q <= comp_q + 2'd1;
        end
        default: ;
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      NS_IDLE: begin
        if (start_i) begin
          for (int i = 0; i < 3; i++) begin
            m_q[i]   <= abs_in[i];
            neg_q[i] <= vec_i[i][34];
            q_q[i]   <= '0;
          end
          frac14_q <= frac14_i;
        end
      end
      NS_SHIFT: begin
        for (int i = 0; i < 3; i++) begin
          if (too_big) m_q[i] <= m_q[i] >> 1;
          else if (too_small) m_q[i] <= m_q[i] << 1;
        end
        sq_q <= '0;
      end
      NS_SQ: begin
        sq_q  <= sq_q + 62'(prod);
        res_q <= '0;
      end
      NS_SQRT: begin
        if (take) begin
          sq_q  <= sq_q - trial[61:0];
          res_q <= (res_q >> 1) + bit_w;
        end else begin
          res_q <= res_q >> 1;
        end
      end
      NS_DINIT: r_q <= r_init;
      NS_DIV: begin
        r_q <= fits ? 32'(r_shift - {1'b0, den}) : r_shift[31:0];
        q_q[comp_q][cnt_q] <= fits;
      end
      default: ;
    endcase
  end

endmodule

/* design/svna_dp.sv */
// Datapath: vertex stores, edge and cross product arithmetic, result register
module svna_dp import svna_pkg::*; #(
  parameter int unsigned MAX_VERTICES = 2048
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic [11:0]        vertex_count_i,
  input  logic [1:0]         opcode_i,
  input  logic [10:0]        vertex_index_i,
  input  logic [10:0]        second_index_i,
  input  logic [10:0]        third_index_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [10:0]        out_vertex_o,
  output logic signed [15:0] normal_x_o,
  output logic signed [15:0] normal_y_o,
  output logic signed [15:0] normal_z_o,
  output logic               no_normal_o
);

  localparam int unsigned AW = $clog2(MAX_VERTICES);

  // Round a Q3.60 value to Q.16, half away from zero
  function automatic logic signed [19:0] rnd_q16(input logic signed [63:0] v);
    logic [63:0] mag;
    logic [19:0] r;
    mag = v[63] ? 64'(-v) : 64'(v);
    r   = 20'((mag + 64'h0000_0800_0000_0000) >> 44);
    return v[63] ? -$signed(r) : $signed(r);
  endfunction

  // Saturating add onto a sum component
  function automatic logic [31:0] sat_add(input logic signed [31:0] s,
                                         input logic signed [19:0] c);
    logic signed [32:0] t;
    t = 33'(s) + 33'(c);
    if (t[32] != t[31]) return t[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    return t[31:0];
  endfunction

  function automatic logic in_rng(input logic [10:0] idx, input logic [11:0] vc);
    return ({1'b0, idx} < vc) && (32'(idx) < MAX_VERTICES);
  endfunction

  // Item registers
  op_e                op_q;
  logic [10:0]        idx_q [3];
  logic signed [31:0] px_q, py_q, pz_q;

  // Stores
  logic [95:0]  pos_mem [MAX_VERTICES];
  logic [111:0] acc_mem [MAX_VERTICES];
  logic [95:0]  pos_rdata_q;
  logic [111:0] acc_rdata_q;
  logic [AW-1:0] clr_ptr_q;

  // Arithmetic registers
  logic signed [31:0] p_q [3][3];
  unit_t              a_q [3], b_q [3];
  logic signed [63:0] prod_q, t_q;
  logic signed [19:0] c_q [3];

  logic               out_valid_q;
  logic [10:0]        out_vertex_q;
  logic signed [15:0] nx_q, ny_q, nz_q;
  logic               no_normal_q;

  logic [10:0]        idx_sel;
  logic [AW-1:0]      addr, acc_waddr;
  logic               pos_we, acc_we;
  logic [111:0]       acc_wdata;
  logic signed [31:0] sum_rd [3];
  logic [15:0]        cnt_rd, cnt_new;
  vec_t               nvec [3];
  logic               norm_done, norm_ok;
  unit_t              unit [3];
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] diff;
  logic               use_n;

  // Corner address
  always_comb begin
    case (cmd_i.corner)
      2'd0:    idx_sel = idx_q[0];
      2'd1:    idx_sel = idx_q[1];
      default: idx_sel = idx_q[2];
    endcase
  end
  assign addr = AW'(idx_sel);

  // Accumulator read fields
  always_comb begin
    for (int k = 0; k < 3; k++) sum_rd[k] = acc_rdata_q[32*k +: 32];
  end
  assign cnt_rd  = acc_rdata_q[111:96];
  assign cnt_new = (cnt_rd == COUNT_MAX) ? cnt_rd : cnt_rd + 16'd1;

  // Accumulator write: clearing sweep or read-modify-write
  assign acc_we    = cmd_i.acc_wr || cmd_i.acc_clr;
  assign acc_waddr = cmd_i.acc_clr ? clr_ptr_q : addr;
  assign acc_wdata = cmd_i.acc_clr ? '0 :
                     {cnt_new, sat_add(sum_rd[2], c_q[2]), sat_add(sum_rd[1], c_q[1]),
                      sat_add(sum_rd[0], c_q[0])};
  assign pos_we    = cmd_i.pos_wr && sts_o.in_range0;

  // Item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q     <= op_e'(opcode_i);
      idx_q[0] <= vertex_index_i;
      idx_q[1] <= second_index_i;
      idx_q[2] <= third_index_i;
      px_q     <= pos_x_i;
      py_q     <= pos_y_i;
      pz_q     <= pos_z_i;
    end
  end

  // Position store
  always_ff @(posedge clk_i) begin
    if (pos_we) pos_mem[addr] <= {pz_q, py_q, px_q};
    if (cmd_i.pos_rd) pos_rdata_q <= pos_mem[addr];
  end

  // Normal sum and use count store
  always_ff @(posedge clk_i) begin
    if (acc_we) acc_mem[acc_waddr] <= acc_wdata;
    if (cmd_i.acc_rd) acc_rdata_q <= acc_mem[addr];
  end

  // Clearing pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_ptr_q <= '0;
    end else if (cmd_i.acc_clr) begin
      clr_ptr_q <= sts_o.clr_last ? '0 : clr_ptr_q + AW'(1);
    end
  end

  // Corner positions
  always_ff @(posedge clk_i) begin
    if (cmd_i.pos_cap) begin
      for (int k = 0; k < 3; k++) begin
        if (cmd_i.corner == 2'(k)) begin
          p_q[k][0] <= pos_rdata_q[31:0];
          p_q[k][1] <= pos_rdata_q[63:32];
          p_q[k][2] <= pos_rdata_q[95:64];
        end
      end
    end
  end

  // Normaliser input select
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      case (cmd_i.norm_sel)
        NSEL_A:  nvec[k] = 35'(p_q[0][k]) - 35'(p_q[1][k]);
        NSEL_B:  nvec[k] = 35'(p_q[0][k]) - 35'(p_q[2][k]);
        default: nvec[k] = 35'(sum_rd[k]);
      endcase
    end
  end

  svna_norm u_norm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.norm_start),
    .frac14_i (cmd_i.norm_sel == NSEL_SUM),
    .vec_i    (nvec),
    .done_o   (norm_done),
    .ok_o     (norm_ok),
    .unit_o   (unit)
  );

  // Unit edge capture
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      if (cmd_i.a_cap) a_q[k] <= unit[k];
      if (cmd_i.b_cap) b_q[k] <= unit[k];
    end
  end

  // Cross product operands, one product a step
  always_comb begin
    case (cmd_i.step)
      3'd0:    begin mul_a = a_q[1]; mul_b = b_q[2]; end
      3'd1:    begin mul_a = a_q[2]; mul_b = b_q[1]; end
      3'd2:    begin mul_a = a_q[2]; mul_b = b_q[0]; end
      3'd3:    begin mul_a = a_q[0]; mul_b = b_q[2]; end
      3'd4:    begin mul_a = a_q[0]; mul_b = b_q[1]; end
      3'd5:    begin mul_a = a_q[1]; mul_b = b_q[0]; end
      default: begin mul_a = a_q[0]; mul_b = b_q[0]; end
    endcase
  end
  assign diff = t_q - prod_q;

  // Cross product sequence
  always_ff @(posedge clk_i) begin
    if (cmd_i.cross_en) begin
      prod_q <= 64'(mul_a) * 64'(mul_b);
      case (cmd_i.step)
        3'd1, 3'd3, 3'd5: t_q <= prod_q;
        3'd2:    c_q[0] <= rnd_q16(diff);
        3'd4:    c_q[1] <= rnd_q16(diff);
        3'd6:    c_q[2] <= rnd_q16(diff);
        default: ;
      endcase
    end
  end

  // Result register
  assign use_n = cmd_i.out_use_norm && norm_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_vertex_q <= idx_q[0];
      nx_q         <= use_n ? unit[0][15:0] : '0;
      ny_q         <= use_n ? unit[1][15:0] : '0;
      nz_q         <= use_n ? unit[2][15:0] : '0;
      no_normal_q  <= !use_n;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_vertex_o = out_vertex_q;
  assign normal_x_o   = nx_q;
  assign normal_y_o   = ny_q;
  assign normal_z_o   = nz_q;
  assign no_normal_o  = no_normal_q;

  // Status
  always_comb begin
    sts_o.op           = op_q;
    sts_o.in_range0    = in_rng(idx_q[0], vertex_count_i);
    sts_o.in_range_all = in_rng(idx_q[0], vertex_count_i) && in_rng(idx_q[1], vertex_count_i)
                         && in_rng(idx_q[2], vertex_count_i);
    sts_o.rd_used      = (cnt_rd != '0);
    sts_o.norm_done    = norm_done;
    sts_o.norm_ok      = norm_ok;
    sts_o.clr_last     = (clr_ptr_q == AW'(MAX_VERTICES - 1));
    sts_o.out_busy     = out_valid_q && !out_ready_i;
  end

endmodule

/* design/svna_ctrl.sv */
// Sequencer for clear, load, triangle and read operations
module svna_ctrl import svna_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output cmd_t cmd_o,
  input  sts_t sts_i
);

  ctrl_state_e state_q, state_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        use_norm_q, use_norm_d;

  // Next state
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    use_norm_d = use_norm_q;
    case (state_q)
      ST_CLR:  if (sts_i.clr_last) state_d = ST_IDLE;
      ST_IDLE: if (in_valid_i) state_d = ST_DECODE;
      ST_DECODE: begin
        cnt_d = '0;
        case (sts_i.op)
          OP_CLEAR: state_d = ST_CLR;
          OP_LOAD:  state_d = ST_LOAD;
          OP_TRI:   state_d = ST_TRI_CHK;
          default:  state_d = ST_RD_RD;
        endcase
      end
      ST_LOAD:    state_d = ST_IDLE;
      ST_TRI_CHK: state_d = sts_i.in_range_all ? ST_TRI_RD : ST_IDLE;
      ST_TRI_RD:  state_d = ST_TRI_CAP;
      ST_TRI_CAP: begin
        if (cnt_q[1:0] == LAST_CORNER) begin
          cnt_d   = '0;
          state_d = ST_NA_GO;
        end else begin
          cnt_d   = cnt_q + 3'd1;
          state_d = ST_TRI_RD;
        end
      end
      ST_NA_GO:   state_d = ST_NA_WAIT;
      ST_NA_WAIT: if (sts_i.norm_done) state_d = ST_NB_GO;
      ST_NB_GO:   state_d = ST_NB_WAIT;
      ST_NB_WAIT: begin
        if (sts_i.norm_done) begin
          cnt_d   = '0;
          state_d = ST_CROSS;
        end
      end
      ST_CROSS: begin
        if (cnt_q == CROSS_LAST) begin
          cnt_d   = '0;
          state_d = ST_ACC_RD;
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      ST_ACC_RD: state_d = ST_ACC_WR;
      ST_ACC_WR: begin
        if (cnt_q[1:0] == LAST_CORNER) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else begin
          cnt_d   = cnt_q + 3'd1;
          state_d = ST_ACC_RD;
        end
      end
      ST_RD_RD: state_d = ST_RD_CHK;
      ST_RD_CHK: begin
        use_norm_d = sts_i.in_range0 && sts_i.rd_used;
        state_d    = (sts_i.in_range0 && sts_i.rd_used) ? ST_RD_WAIT : ST_RES;
      end
      ST_RD_WAIT: if (sts_i.norm_done) state_d = ST_RES;
      ST_RES:     if (!sts_i.out_busy) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o          = '0;
    cmd_o.norm_sel = NSEL_SUM;
    cmd_o.corner   = cnt_q[1:0];
    cmd_o.step     = cnt_q;
    in_ready_o     = (state_q == ST_IDLE);
    case (state_q)
      ST_CLR:  cmd_o.acc_clr = 1'b1;
      ST_IDLE: cmd_o.accept  = in_valid_i;
      ST_LOAD: begin
        cmd_o.corner = CORNER0;
        cmd_o.pos_wr = 1'b1;
      end
      ST_TRI_RD:  cmd_o.pos_rd  = 1'b1;
      ST_TRI_CAP: cmd_o.pos_cap = 1'b1;
      ST_NA_GO: begin
        cmd_o.norm_sel   = NSEL_A;
        cmd_o.norm_start = 1'b1;
      end
      ST_NA_WAIT: cmd_o.a_cap = sts_i.norm_done;
      ST_NB_GO: begin
        cmd_o.norm_sel   = NSEL_B;
        cmd_o.norm_start = 1'b1;
      end
      ST_NB_WAIT: cmd_o.b_cap    = sts_i.norm_done;
      ST_CROSS:   cmd_o.cross_en = 1'b1;
      ST_ACC_RD:  cmd_o.acc_rd   = 1'b1;
      ST_ACC_WR:  cmd_o.acc_wr   = 1'b1;
      ST_RD_RD: begin
        cmd_o.corner = CORNER0;
        cmd_o.acc_rd = 1'b1;
      end
      ST_RD_CHK: cmd_o.norm_start = sts_i.in_range0 && sts_i.rd_used;
      ST_RES: begin
        cmd_o.out_load     = !sts_i.out_busy;
        cmd_o.out_use_norm = use_norm_q;
      end
      default: ;
    endcase
  end

  // State registers; reset starts with a clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLR;
      cnt_q      <= '0;
      use_norm_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      use_norm_q <= use_norm_d;
    end
  end

endmodule
